FILE: rtl/cttc_pkg.sv
// ----------------------------------------------------------------------------
// cttc_pkg: shared types and constants of the cEMI to TP telegram converter
// Holds the verdict codes, the frame constants and the record that the front
// part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package cttc_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [8:0] POS_MAX   = 9'd511;
	localparam logic [8:0] POS_MSG   = 9'd0;
	localparam logic [8:0] POS_ADDIL = 9'd1;
	localparam logic [8:0] POS_CTRL1 = 9'd2;
	localparam logic [8:0] POS_CTRL2 = 9'd3;
	localparam logic [8:0] POS_LEN   = 9'd8;
	localparam logic [8:0] LEN_EXTRA = 9'd10;

	localparam logic [7:0] CHECK_INIT = 8'hFF;
	localparam logic [7:0] HI_MASK    = 8'hF0;
	localparam logic [7:0] LO_MASK    = 8'h0F;
	localparam logic [7:0] RSV_MASK   = 8'h40;
	localparam logic [7:0] LEN_BAD    = 8'hFF;
	localparam logic [7:0] STD_MAXLEN = 8'd15;

	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_LEN_MISM = 3'd1,
		VERDICT_RESERVED = 3'd2,
		VERDICT_CTRL2    = 3'd3,
		VERDICT_LEN_FF   = 3'd4,
		VERDICT_TOO_LONG = 3'd5
	} verdict_t;

	// One queue record: an optional telegram byte, an optional check octet.
	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic       has_check;
		logic [7:0] check;
		verdict_t   verdict;
	} entry_t;

endpackage

FILE: rtl/cttc_front.sv
// ----------------------------------------------------------------------------
// cttc_front: frame parser
// Tracks the position in the cEMI frame, skips additional info, builds the
// telegram byte, the running check and the verdict, and writes a record.
// ----------------------------------------------------------------------------
module cttc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       frame_byte,
	input  logic             frame_end,
	output logic             wr,
	output cttc_pkg::entry_t wr_entry
);
	import cttc_pkg::*;

	logic [8:0] position_q;
	logic [7:0] skip_left_q;
	logic [7:0] saved_ctrl_two_q;
	logic       is_standard_q;
	logic [7:0] running_check_q;
	logic [7:0] payload_count_q;
	verdict_t   error_code_q;

	logic [8:0] pos_n;
	logic [7:0] skip_n;
	logic [7:0] ctrl2_n;
	logic       std_n;
	logic [7:0] chk_n;
	logic [7:0] pc_n;
	verdict_t   err_n;
	verdict_t   cand;
	logic       counted;
	logic       emit;
	logic [7:0] eb;
	logic       mismatch;

	always_comb begin
		skip_n  = skip_left_q;
		ctrl2_n = saved_ctrl_two_q;
		std_n   = is_standard_q;
		pc_n    = payload_count_q;
		cand    = VERDICT_OK;
		counted = 1'b1;
		emit    = 1'b0;
		eb      = frame_byte;
		if (position_q == POS_MSG) begin
			emit = 1'b0;
		end else if (position_q == POS_ADDIL) begin
			skip_n = frame_byte;
		end else if (skip_left_q != 8'd0) begin
			skip_n  = skip_left_q - 8'd1;
			counted = 1'b0;
		end else if (position_q == POS_CTRL1) begin
			std_n = frame_byte[7];
			if ((frame_byte & RSV_MASK) != 8'd0) cand = VERDICT_RESERVED;
			emit = 1'b1;
		end else if (position_q == POS_CTRL2) begin
			ctrl2_n = frame_byte;
			if ((frame_byte & LO_MASK) != 8'd0) cand = VERDICT_CTRL2;
			emit = ~is_standard_q;
		end else if (position_q == POS_LEN) begin
			pc_n = frame_byte;
			if (frame_byte == LEN_BAD) cand = VERDICT_LEN_FF;
			else if (frame_byte > STD_MAXLEN && is_standard_q) cand = VERDICT_TOO_LONG;
			emit = 1'b1;
			if (is_standard_q)
				eb = (saved_ctrl_two_q & HI_MASK) | (frame_byte & LO_MASK);
		end else begin
			emit = 1'b1;
		end

		pos_n = (counted && position_q < POS_MAX) ? position_q + 9'd1 : position_q;
		chk_n = emit ? running_check_q ^ eb : running_check_q;
		err_n = (error_code_q == VERDICT_OK) ? cand : error_code_q;
		mismatch = (skip_n != 8'd0) || (pos_n != ({1'b0, pc_n} + LEN_EXTRA));
	end

	assign wr = accept & (emit | frame_end);

	always_comb begin
		wr_entry.has_data  = emit;
		wr_entry.data      = eb;
		wr_entry.has_check = frame_end;
		wr_entry.check     = chk_n;
		wr_entry.verdict   = mismatch ? VERDICT_LEN_MISM : err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q       <= '0;
			skip_left_q      <= '0;
			saved_ctrl_two_q <= '0;
			is_standard_q    <= 1'b0;
			running_check_q  <= CHECK_INIT;
			payload_count_q  <= '0;
			error_code_q     <= VERDICT_OK;
		end else if (accept) begin
			if (frame_end) begin
				position_q       <= '0;
				skip_left_q      <= '0;
				saved_ctrl_two_q <= '0;
				is_standard_q    <= 1'b0;
				running_check_q  <= CHECK_INIT;
				payload_count_q  <= '0;
				error_code_q     <= VERDICT_OK;
			end else begin
				position_q       <= pos_n;
				skip_left_q      <= skip_n;
				saved_ctrl_two_q <= ctrl2_n;
				is_standard_q    <= std_n;
				running_check_q  <= chk_n;
				payload_count_q  <= pc_n;
				error_code_q     <= err_n;
			end
		end
	end

endmodule

FILE: rtl/cttc_queue.sv
// ----------------------------------------------------------------------------
// cttc_queue: record queue
// A short circular queue that decouples the parser from the output side.
// ----------------------------------------------------------------------------
module cttc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  cttc_pkg::entry_t wr_entry,
	output logic             q_full,
	input  logic             rd,
	output logic             q_empty,
	output cttc_pkg::entry_t rd_entry
);
	import cttc_pkg::*;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
	localparam logic [QPTR_W-1:0] PTR_ONE  = QPTR_W'(1);
	localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);
	localparam logic [QCNT_W-1:0] CNT_ONE  = QCNT_W'(1);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full   = (count_q == CNT_FULL);
	assign q_empty  = (count_q == '0);
	assign do_wr    = wr & ~q_full;
	assign do_rd    = rd & ~q_empty;
	assign rd_entry = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_ONE;
			if (do_rd) rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_ONE;
			if (do_wr && !do_rd) count_q <= count_q + CNT_ONE;
			else if (do_rd && !do_wr) count_q <= count_q - CNT_ONE;
		end
	end

endmodule

FILE: rtl/cttc_back.sv
// ----------------------------------------------------------------------------
// cttc_back: output serializer
// Turns each record into one or two output words and holds the oldest word
// in an output register until it is popped.
// ----------------------------------------------------------------------------
module cttc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  cttc_pkg::entry_t rd_entry,
	output logic             rd,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       tele_byte,
	output logic             tele_end,
	output logic [2:0]       verdict
);
	import cttc_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;
	verdict_t   out_verdict_q;
	logic       pend_valid_q;
	logic [7:0] pend_byte_q;
	verdict_t   pend_verdict_q;
	logic       slot_free;

	assign slot_free = ~out_valid_q | pop;
	// A held check octet goes out before the next record is taken.
	assign rd        = slot_free & ~pend_valid_q & ~q_empty;

	assign empty     = ~out_valid_q;
	assign tele_byte = out_byte_q;
	assign tele_end  = out_end_q;
	assign verdict   = out_verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= rd_entry.has_data & rd_entry.has_check;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (pend_valid_q) begin
				out_byte_q    <= pend_byte_q;
				out_end_q     <= 1'b1;
				out_verdict_q <= pend_verdict_q;
			end else if (!q_empty) begin
				if (rd_entry.has_data) begin
					out_byte_q    <= rd_entry.data;
					out_end_q     <= 1'b0;
					out_verdict_q <= VERDICT_OK;
				end else begin
					out_byte_q    <= rd_entry.check;
					out_end_q     <= 1'b1;
					out_verdict_q <= rd_entry.verdict;
				end
				pend_byte_q    <= rd_entry.check;
				pend_verdict_q <= rd_entry.verdict;
			end
		end
	end

endmodule

FILE: rtl/cemi_to_tp_telegram_converter.sv
// ----------------------------------------------------------------------------
// cemi_to_tp_telegram_converter: cEMI frame to twisted-pair telegram
// A telegram byte enters the record queue when its cEMI word is accepted and then
// moves to the output register. Throughput: one cEMI word per cycle unless full;
// a final word that also carries a byte yields two output words, popped in turn.
// The rate is set by the single output register draining the record queue.
// Reset: arst_n clears the parser state and empties the queue and output.
// ----------------------------------------------------------------------------
module cemi_to_tp_telegram_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] frame_byte,
	input  logic       frame_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] tele_byte,
	output logic       tele_end,
	output logic [2:0] verdict
);
	import cttc_pkg::*;

	logic   accept;
	logic   wr;
	entry_t wr_entry;
	logic   q_full;
	logic   q_empty;
	logic   rd;
	entry_t rd_entry;

	assign full   = q_full;
	assign accept = push & ~q_full;

	cttc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.wr         (wr),
		.wr_entry   (wr_entry)
	);

	cttc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_entry (wr_entry),
		.q_full   (q_full),
		.rd       (rd),
		.q_empty  (q_empty),
		.rd_entry (rd_entry)
	);

	cttc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.rd_entry  (rd_entry),
		.rd        (rd),
		.empty     (empty),
		.pop       (pop),
		.tele_byte (tele_byte),
		.tele_end  (tele_end),
		.verdict   (verdict)
	);

endmodule

FILE: verif/cemi_to_tp_telegram_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cemi_to_tp_telegram_converter_tb: self-checking bench for the converter
// cEMI frames are pushed one word at a time. Well-formed frames, frames with
// field faults, truncated frames, overlong frames and random noise are all
// sent. A built-in converter model predicts each telegram word and check
// octet, and every popped word is compared with the oldest prediction. The
// sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module cemi_to_tp_telegram_converter_tb;
	import cttc_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
		verdict_t   code;
	} tele_word_t;

	typedef enum int {
		POP_ALWAYS,
		POP_HALF,
		POP_SPARSE,
		POP_PERIODIC
	} pop_mode_t;

	localparam int MAX_PRINTS = 40;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] frame_byte;
	logic       frame_end;
	logic       empty;
	logic       pop;
	logic [7:0] tele_byte;
	logic       tele_end;
	logic [2:0] verdict;

	tele_word_t tele_words_due[$];
	logic [7:0] frame_words[$];
	int         error_count = 0;
	int         hold_cycles = 0;
	int         burst_left  = 0;
	int         words_sent  = 0;

	// Converter model state.
	logic [8:0] parse_pos;
	logic [7:0] skip_count;
	logic [7:0] ctrl2_seen;
	logic [7:0] len_octet;
	logic [7:0] check_acc;
	logic       std_frame;
	verdict_t   first_fault;

	cemi_to_tp_telegram_converter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.empty      (empty),
		.pop        (pop),
		.tele_byte  (tele_byte),
		.tele_end   (tele_end),
		.verdict    (verdict)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < MAX_PRINTS)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic clear_parse();
		parse_pos   = '0;
		skip_count  = '0;
		ctrl2_seen  = '0;
		len_octet   = '0;
		check_acc   = CHECK_INIT;
		std_frame   = 1'b0;
		first_fault = VERDICT_OK;
	endtask

	task automatic note_fault(input verdict_t code);
		if (first_fault == VERDICT_OK)
			first_fault = code;
	endtask

	// Works out the telegram words that one accepted cEMI word produces.
	task automatic convert_word(input logic [7:0] b, input logic last);
		logic       counted;
		logic       emit;
		logic       mismatch;
		logic [7:0] out_b;
		counted = 1'b1;
		emit    = 1'b0;
		out_b   = '0;
		if (parse_pos == POS_MSG) begin
			// The message code is dropped.
		end else if (parse_pos == POS_ADDIL) begin
			skip_count = b;
		end else if (skip_count != 0) begin
			skip_count--;
			counted = 1'b0;
		end else if (parse_pos == POS_CTRL1) begin
			std_frame = b[7];
			if ((b & RSV_MASK) != 0)
				note_fault(VERDICT_RESERVED);
			emit  = 1'b1;
			out_b = b;
		end else if (parse_pos == POS_CTRL2) begin
			ctrl2_seen = b;
			if ((b & LO_MASK) != 0)
				note_fault(VERDICT_CTRL2);
			if (!std_frame) begin
				emit  = 1'b1;
				out_b = b;
			end
		end else if (parse_pos == POS_LEN) begin
			len_octet = b;
			if (b == LEN_BAD)
				note_fault(VERDICT_LEN_FF);
			else if (b > STD_MAXLEN && std_frame)
				note_fault(VERDICT_TOO_LONG);
			emit  = 1'b1;
			out_b = std_frame ? ((ctrl2_seen & HI_MASK) | (b & LO_MASK)) : b;
		end else begin
			emit  = 1'b1;
			out_b = b;
		end
		if (counted && parse_pos < POS_MAX)
			parse_pos++;
		if (emit) begin
			check_acc = check_acc ^ out_b;
			tele_words_due.push_back('{out_b, 1'b0, VERDICT_OK});
		end
		if (last) begin
			mismatch = (skip_count != 0) || (parse_pos != ({1'b0, len_octet} + LEN_EXTRA));
			tele_words_due.push_back('{check_acc, 1'b1,
				mismatch ? VERDICT_LEN_MISM : first_fault});
			clear_parse();
		end
	endtask

	// Offers one word; push stays high across back-to-back words of a burst.
	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		push       <= 1'b1;
		frame_byte <= b;
		frame_end  <= last;
		do @(posedge clk); while (full);
		convert_word(b, last);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic send_frame();
		foreach (frame_words[i])
			send_word(frame_words[i], i == frame_words.size() - 1);
	endtask

	// Header, optional additional info, address fields, length octet, then tail_n bytes.
	task automatic build_frame(input logic [7:0] ctrl1, input logic [7:0] ctrl2,
			input int addil_n, input logic [7:0] len, input int tail_n);
		frame_words.delete();
		frame_words.push_back(8'($urandom_range(0, 255)));
		frame_words.push_back(addil_n[7:0]);
		repeat (addil_n) frame_words.push_back(8'($urandom_range(0, 255)));
		frame_words.push_back(ctrl1);
		frame_words.push_back(ctrl2);
		repeat (4) frame_words.push_back(8'($urandom_range(0, 255)));
		frame_words.push_back(len);
		repeat (tail_n) frame_words.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic truncate_frame(input int keep);
		while (frame_words.size() > keep)
			void'(frame_words.pop_back());
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (tele_words_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_good_frames();
		build_frame(8'hBC, 8'hE0, 0, 8'd1, 2);
		send_frame();
		build_frame(8'h3C, 8'h60, 2, 8'd20, 21);
		send_frame();
		build_frame(8'hB0, 8'hF0, 1, 8'd15, 16);
		send_frame();
		build_frame(8'h00, 8'h00, 0, 8'd0, 1);
		send_frame();
	endtask

	task automatic test_field_faults();
		build_frame(8'hFC, 8'hE0, 0, 8'd2, 3);
		send_frame();
		build_frame(8'hBC, 8'h0F, 0, 8'd2, 3);
		send_frame();
		// Reserved bit and ctrl2 nibble together: the ctrl1 fault wins.
		build_frame(8'hF0, 8'h01, 0, 8'd1, 2);
		send_frame();
		build_frame(8'hBC, 8'h70, 0, 8'd16, 17);
		send_frame();
		// A short frame with a bad length reports the length mismatch instead.
		build_frame(8'hBC, 8'h60, 0, LEN_BAD, 3);
		send_frame();
	endtask

	task automatic test_length_mismatch();
		build_frame(8'hBC, 8'hE0, 0, 8'd4, 4);
		send_frame();
		build_frame(8'h3C, 8'h60, 0, 8'd4, 6);
		send_frame();
		build_frame(8'hBC, 8'hE0, 0, 8'd1, 2);
		truncate_frame(1);
		send_frame();
		build_frame(8'hBC, 8'hE0, 3, 8'd1, 2);
		truncate_frame(2);
		send_frame();
		build_frame(8'hBC, 8'hE0, 5, 8'd1, 2);
		truncate_frame(4);
		send_frame();
		build_frame(8'h3C, 8'h60, 0, 8'd1, 2);
		truncate_frame(4);
		send_frame();
	endtask

	// A long additional-info skip, then a long extended frame.
	task automatic test_long_frames();
		build_frame(8'hBC, 8'hE0, 20, 8'd3, 4);
		send_frame();
		build_frame(8'h3C, 8'h60, 0, 8'd30, 31);
		send_frame();
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_cycles = 120;
		build_frame(8'h3C, 8'h60, 1, 8'd30, 31);
		send_frame();
		wait_drained();
	endtask

	task automatic test_random(input int n_words);
		int         target;
		int         pick;
		int         addil_n;
		int         tail_n;
		logic       std;
		logic [7:0] ctrl1;
		logic [7:0] ctrl2;
		logic [7:0] len;
		target = words_sent + n_words;
		while (words_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick <= 7) begin
				std   = 1'($urandom_range(0, 1));
				ctrl1 = 8'($urandom_range(0, 255));
				ctrl1[7] = std;
				if ($urandom_range(0, 9) != 0)
					ctrl1[6] = 1'b0;
				ctrl2 = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) != 0)
					ctrl2[3:0] = 4'h0;
				addil_n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) :
					$urandom_range(0, 3);
				if (std)
					len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 24)) :
						8'($urandom_range(0, 15));
				else
					len = 8'($urandom_range(0, 30));
				tail_n = int'(len) + 1;
				if ($urandom_range(0, 9) == 0)
					tail_n = tail_n + $urandom_range(0, 2) - 1;
				build_frame(ctrl1, ctrl2, addil_n, len, tail_n);
				// Broken frames are cut at a random point, which may keep every word.
				if (pick == 7)
					truncate_frame($urandom_range(1, frame_words.size()));
			end else begin
				frame_words.delete();
				repeat ($urandom_range(1, 16))
					frame_words.push_back(8'($urandom_range(0, 255)));
			end
			send_frame();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
	endtask

	// Receiver: the stall pattern is picked anew at random; a test can force a long hold.
	initial begin
		pop_mode_t mode;
		int        mode_left;
		mode      = POP_ALWAYS;
		mode_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = pop_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					POP_ALWAYS: pop <= 1'b1;
					POP_HALF:   pop <= ($urandom_range(0, 1) == 1);
					POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
					default:    pop <= (mode_left % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		tele_word_t want;
		if (arst_n && pop && !empty) begin
			if (tele_words_due.size() == 0) begin
				report_mismatch("telegram word with nothing pending", int'(tele_byte), 0);
			end else begin
				want = tele_words_due.pop_front();
				if (tele_byte !== want.data)
					report_mismatch("tele_byte", int'(tele_byte), int'(want.data));
				if (tele_end !== want.last)
					report_mismatch("tele_end", int'(tele_end), int'(want.last));
				if (verdict !== want.code)
					report_mismatch("verdict", int'(verdict), int'(want.code));
			end
		end
	end

	initial begin
		push       <= 1'b0;
		frame_byte <= '0;
		frame_end  <= 1'b0;
		arst_n     <= 1'b0;
		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 24);

		test_good_frames();
		test_field_faults();
		test_length_mismatch();
		test_long_frames();
		test_backpressure();
		test_random(150);

		wait_drained();
		repeat (20) @(posedge clk);
		if (tele_words_due.size() != 0)
			report_mismatch("telegram words never produced", 0, tele_words_due.size());
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
